### rtl/packet_error_rate_tracker_core_defines.svh
// assertion macros for the packet error rate tracker
// used by rtl/packet_error_rate_tracker_core.sv, expects clk and rst_n in scope
`ifndef PACKET_ERROR_RATE_TRACKER_CORE_DEFINES_SVH
`define PACKET_ERROR_RATE_TRACKER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PERT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PERT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pert_pkg.sv
// types and constants for the packet error rate tracker
// no dependencies
package pert_pkg;

  typedef struct packed {
    logic        func;
    logic        crc_ok;
    logic [7:0]  frame_length;
    logic [15:0] seq_number;
  } pert_in_t;

  typedef struct packed {
    logic [15:0] received_total;
    logic [15:0] missed_total;
    logic [6:0]  error_percent;
    logic        frame_fault;
    logic        restart_rx;
    logic        report;
  } pert_out_t;

  localparam logic [15:0] UNSET_INDEX    = 16'hFFFF;
  localparam logic [8:0]  FRAME_OVERHEAD = 9'd4;
  localparam logic [8:0]  MAX_DATA_BYTES = 9'd6;
  localparam logic [6:0]  PCT_FULL       = 7'd100;
  localparam int          DIV_W          = 23;
  localparam logic        FUNC_FRAME     = 1'b0;
  localparam logic        FUNC_RESTART   = 1'b1;

  // 16 = 1 mod 5, so the nibble sum keeps the residue
  function automatic logic is_mult5(input logic [15:0] v);
    logic [5:0] s1;
    logic [4:0] s2;
    s1 = 6'(v[3:0]) + 6'(v[7:4]) + 6'(v[11:8]) + 6'(v[15:12]);
    s2 = 5'(s1[5:4]) + 5'(s1[3:0]);
    return (s2 == 5'd0) || (s2 == 5'd5) || (s2 == 5'd10) || (s2 == 5'd15);
  endfunction

endpackage

### rtl/packet_error_rate_tracker_core.sv
// packet error rate tracker core: counters, sequencer and shared divider
// depends on pert_pkg and packet_error_rate_tracker_core_defines.svh
//
// usage:
//   input channel in_valid/in_stall/in_data carries one event per transaction:
//   a received frame (func = 0) or a measurement restart (func = 1)
//   every input transaction yields exactly one result on out_valid/out_stall/out_data
//   with the counters after the event, the error percentage and the flags
// sequencing:
//   restart and faulty frames go from anchor straight to done; good frames
//   pass classify and prep and go to done when the span is not positive,
//   or after check when the ratio is full; else the percentage comes from a
//   restoring divider that retires one quotient bit a cycle through a single
//   shared subtractor (seven bits); in_stall stays high until the result is
//   loaded in the output register, so one transaction is in work at a time
// reset: synchronous, active low; start index unset, counters clear, no result
// receiver stall:
//   the result register holds while out_stall is high; a new event may be accepted
//   meanwhile, and its result waits in the sequencer until the register frees
`include "packet_error_rate_tracker_core_defines.svh"

module packet_error_rate_tracker_core
  import pert_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  pert_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output pert_out_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_ANCHOR, S_CLASSIFY, S_PREP, S_CHECK, S_DIV, S_FIN, S_DONE
  } state_t;

  state_t            state_r;
  pert_in_t          item_r;
  logic [15:0]       start_r;
  logic [15:0]       rcv_r;
  logic [15:0]       miss_r;
  logic [15:0]       pos_r;
  logic [15:0]       exp_r;
  logic [15:0]       span_s_r;
  logic [DIV_W-1:0]  rem_r;
  logic [6:0]        q_r;
  logic [2:0]        k_r;
  logic [6:0]        pct_r;
  logic              fault_r;
  logic              restart_r;
  logic              report_r;
  logic              out_valid_r;
  pert_out_t         out_r;

  logic              bad_len;
  logic              anchor;
  logic [16:0]       span;
  logic [DIV_W-1:0]  alu_b;
  logic [DIV_W:0]    alu_diff;
  logic              alu_borrow;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign bad_len = (9'(item_r.frame_length) < FRAME_OVERHEAD) ||
                   (9'(item_r.frame_length) > FRAME_OVERHEAD + MAX_DATA_BYTES);
  assign anchor  = (start_r == UNSET_INDEX) || (item_r.seq_number == 16'd1);
  assign span    = {1'b0, item_r.seq_number} - {1'b0, start_r};

  // shared compare and subtract unit
  always_comb begin
    if (state_r == S_CHECK) begin
      alu_b = DIV_W'(span_s_r) * DIV_W'(PCT_FULL);
    end else begin
      alu_b = DIV_W'(span_s_r) << k_r;
    end
    alu_diff   = {1'b0, rem_r} - {1'b0, alu_b};
    alu_borrow = alu_diff[DIV_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= UNSET_INDEX;
      rcv_r       <= '0;
      miss_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r    <= in_data;
            fault_r   <= 1'b0;
            restart_r <= 1'b0;
            report_r  <= 1'b0;
            pct_r     <= '0;
            state_r   <= S_ANCHOR;
          end
        end
        S_ANCHOR: begin
          if (item_r.func == FUNC_RESTART) begin
            start_r <= UNSET_INDEX;
            rcv_r   <= '0;
            miss_r  <= '0;
            pos_r   <= '0;
            state_r <= S_DONE;
          end else if (!item_r.crc_ok || bad_len) begin
            miss_r  <= miss_r + 16'd1;
            fault_r <= 1'b1;
            state_r <= S_DONE;
          end else begin
            if (anchor) begin
              start_r <= item_r.seq_number - 16'd1;
              rcv_r   <= '0;
              miss_r  <= '0;
              pos_r   <= '0;
              exp_r   <= item_r.seq_number;
            end else begin
              exp_r   <= pos_r + 16'd1 + start_r;
            end
            report_r <= is_mult5(item_r.seq_number);
            state_r  <= S_CLASSIFY;
          end
        end
        S_CLASSIFY: begin
          if (item_r.seq_number == exp_r) begin
            rcv_r <= rcv_r + 16'd1;
            pos_r <= pos_r + 16'd1;
          end else if (item_r.seq_number > exp_r) begin
            miss_r <= miss_r + (item_r.seq_number - exp_r);
            pos_r  <= item_r.seq_number - start_r;
          end else begin
            restart_r <= 1'b1;
          end
          state_r <= S_PREP;
        end
        S_PREP: begin
          if (span[16] || (span == 17'd0)) begin
            state_r <= S_DONE;
          end else begin
            span_s_r <= span[15:0];
            rem_r    <= DIV_W'(rcv_r) * DIV_W'(PCT_FULL) + DIV_W'(span[15:0]) -
                        DIV_W'(1);
            q_r      <= '0;
            k_r      <= 3'd6;
            state_r  <= S_CHECK;
          end
        end
        S_CHECK: begin
          // ceil ratio of 100 or more gives zero percent
          if (!alu_borrow) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (!alu_borrow) begin
            rem_r     <= alu_diff[DIV_W-1:0];
            q_r[k_r]  <= 1'b1;
          end
          if (k_r == 3'd0) begin
            state_r <= S_FIN;
          end else begin
            k_r <= k_r - 3'd1;
          end
        end
        S_FIN: begin
          pct_r   <= PCT_FULL - q_r;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_r.received_total <= rcv_r;
            out_r.missed_total   <= miss_r;
            out_r.error_percent  <= pct_r;
            out_r.frame_fault    <= fault_r;
            out_r.restart_rx     <= restart_r;
            out_r.report         <= report_r;
            out_valid_r          <= 1'b1;
            state_r              <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `PERT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
                    "accepted transaction did not start work")
  `PERT_ASSERT_NOW(a_pct_range, out_valid, out_data.error_percent <= PCT_FULL,
                   "error percent above 100")
  `PERT_ASSERT_NOW(a_fault_quiet, out_valid && out_data.frame_fault,
                   (out_data.error_percent == 7'd0) && !out_data.report &&
                   !out_data.restart_rx, "faulty frame carries flags")
  `PERT_ASSERT_NOW(a_div_quotient, state_r == S_FIN, q_r < PCT_FULL,
                   "quotient not below 100")

endmodule
